[src/plct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package plct_pkg;

    // table size and derived widths
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int AMOUNT_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int FREED_W  = 7;
    localparam int IDLE_W   = 16;
    localparam int CFG_W    = 16;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] CONNECT_LIMIT_RST = 16'd100;
    localparam logic [CFG_W-1:0] IDLE_LIMIT_RST    = 16'd300;

    // register indexes
    localparam logic REG_CONNECT_LIMIT = 1'b0;
    localparam logic REG_IDLE_LIMIT    = 1'b1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // saturation values
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [IDLE_W-1:0]  IDLE_MAX  = {IDLE_W{1'b1}};
    localparam logic [FREED_W-1:0] FREED_MAX = {FREED_W{1'b1}};

    // one table entry as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [IDLE_W-1:0]  idle;
    } entry_t;

    // request into the table engine
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        logic [AMOUNT_W-1:0] amount;
    } req_t;

    // result out of the table engine
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_now;
        logic [FREED_W-1:0]  freed;
    } res_t;

    // configuration registers
    typedef struct packed {
        logic [CFG_W-1:0] connect_limit;
        logic [CFG_W-1:0] idle_limit;
    } cfg_t;

endpackage

`default_nettype wire

[src/plct_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module plct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read that holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/plct_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module plct_engine
    import plct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]               state_reg, state_next;
    req_t                     req_reg, req_next;
    logic [CNT_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]         ev_idx_reg, ev_idx_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [FREED_W-1:0]       freed_reg, freed_next;
    res_t                     res_reg, res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    // entry store
    plct_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // sweep, read-modify-write and result sequencing
    always_comb
    begin
        entry_t              base;
        logic                ev_valid;
        logic                hit_now;
        logic [IDLE_W-1:0]   idle_inc;
        logic [COUNT_W:0]    sum;
        logic [COUNT_W-1:0]  new_count;
        logic [STATUS_W-1:0] status;

        state_next    = state_reg;
        req_next      = req_reg;
        rd_cnt_next   = rd_cnt_reg;
        ev_vld_next   = 1'b0;
        ev_idx_next   = ev_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        freed_next    = freed_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = ev_idx_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = rd_cnt_reg[IDX_W-1:0];
        base          = ram_rdata;
        ev_valid      = valid_reg[ev_idx_reg];
        hit_now       = 1'b0;
        idle_inc      = (ram_rdata.idle == IDLE_MAX) ? IDLE_MAX : ram_rdata.idle + 1'b1;
        sum           = '0;
        new_count     = '0;
        status        = STAT_DONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    rd_cnt_next   = '0;
                    hit_next      = 1'b0;
                    free_vld_next = 1'b0;
                    freed_next    = '0;
                    if (req.cmd inside {CMD_OPEN, CMD_CLOSE, CMD_TICK})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        res_next   = '{status: STAT_DONE, count_now: '0, freed: '0};
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // look at the entry read in the previous cycle
                if (ev_vld_reg)
                begin
                    if (req_reg.cmd == CMD_TICK)
                    begin
                        if (ev_valid)
                        begin
                            if (ram_rdata.count == '0 && idle_inc > cfg.idle_limit)
                            begin
                                valid_next[ev_idx_reg] = 1'b0;
                                if (freed_reg != FREED_MAX)
                                begin
                                    freed_next = freed_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = ev_idx_reg;
                                ram_wdata      = ram_rdata;
                                ram_wdata.idle = idle_inc;
                            end
                        end
                    end
                    else
                    begin
                        if (ev_valid && ram_rdata.addr == req_reg.addr)
                        begin
                            hit_now      = 1'b1;
                            hit_next     = 1'b1;
                            hit_idx_next = ev_idx_reg;
                        end
                        else if (!ev_valid && !free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = ev_idx_reg;
                        end
                    end
                end

                // issue the next read unless the table is exhausted or the lookup has hit
                if (rd_cnt_reg != CNT_W'(TABLE_ENTRIES) && !hit_now && !hit_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = rd_cnt_reg[IDX_W-1:0];
                end

                // sweep drained
                if (!ev_vld_reg && (hit_reg || rd_cnt_reg == CNT_W'(TABLE_ENTRIES)))
                begin
                    if (req_reg.cmd == CMD_TICK)
                    begin
                        res_next   = '{status: STAT_DONE, count_now: '0, freed: freed_reg};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_APPLY:
            begin
                if (!hit_reg && !free_vld_reg)
                begin
                    res_next = '{status: STAT_FULL, count_now: '0, freed: '0};
                end
                else
                begin
                    // hit keeps the read data, a fresh entry starts empty
                    if (!hit_reg)
                    begin
                        base       = '{addr: req_reg.addr, count: '0, idle: '0};
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    new_count = base.count;
                    if (req_reg.cmd == CMD_OPEN)
                    begin
                        if (base.count >= cfg.connect_limit)
                        begin
                            status = STAT_REFUSED;
                        end
                        else
                        begin
                            sum       = {1'b0, base.count} + (COUNT_W+1)'(req_reg.amount);
                            new_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                        end
                    end
                    else
                    begin
                        base.idle = '0;
                        if (base.count >= COUNT_W'(req_reg.amount))
                        begin
                            new_count = base.count - COUNT_W'(req_reg.amount);
                        end
                    end
                    ram_we          = 1'b1;
                    ram_waddr       = hit_reg ? hit_idx_reg : free_idx_reg;
                    ram_wdata       = base;
                    ram_wdata.count = new_count;
                    res_next        = '{status: status, count_now: new_count, freed: '0};
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            ev_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            ev_vld_reg <= ev_vld_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rd_cnt_reg   <= rd_cnt_next;
        ev_idx_reg   <= ev_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        freed_reg    <= freed_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

[src/per_source_connection_limit_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: source_addr, amount
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: count_now, freed_entries
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// one request at a time; each open, close or tick sweeps the entry memory
// through its single read port, one entry a cycle; an open or close stops
// early on a hit, and an unused command skips the sweep
// reset clears the per-entry valid flags at once, so no clearing pass follows
// a finished result waits in the output register while the next request is
// taken; a stalled output holds the engine once its next result is ready

module per_source_connection_limit_table
    import plct_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,   // source_addr[31:0], amount[39:32]
    input  wire logic [CMD_W-1:0] s_tuser,   // cmd[1:0]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata,   // count_now[15:0], freed_entries[22:16], pad
    output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    req_t req;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic m_tvalid_reg, m_tvalid_next;
    res_t m_res_reg, m_res_next;

    // configuration write port
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CONNECT_LIMIT: cfg_next.connect_limit = cfg_data;
                REG_IDLE_LIMIT:    cfg_next.idle_limit    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // unpack the incoming request
    assign req = '{cmd: s_tuser, addr: s_tdata[31:0], amount: s_tdata[39:32]};

    plct_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '{connect_limit: CONNECT_LIMIT_RST, idle_limit: IDLE_LIMIT_RST};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {1'b0, m_res_reg.freed, m_res_reg.count_now};

`ifndef SYNTHESIS
    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

    // only a tick reports freed entries, and it carries no count
    a_freed_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[22:16] != '0) |-> (m_tuser == STAT_DONE && m_tdata[15:0] == '0))
        else $error("freed entries reported with a count or bad status");

    // a full table reports no count
    a_full_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[15:0] == '0 && m_tdata[22:16] == '0))
        else $error("table full result carries data");

    // a connect limit register write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_CONNECT_LIMIT) |=> (cfg_reg.connect_limit == $past(cfg_data)))
        else $error("connect limit write lost");
`endif

endmodule

`default_nettype wire

[sim/tb_per_source_connection_limit_table.sv]
`timescale 1ns / 1ps

module tb_per_source_connection_limit_table;
    import plct_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE   = 72;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;

    // command code with no function in the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata   = '0;   // source_addr[31:0], amount[39:32]
    logic [CMD_W-1:0]    s_tuser   = '0;   // cmd[1:0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [23:0]         m_tdata;          // count_now[15:0], freed_entries[22:16], pad
    logic [STATUS_W-1:0] m_tuser;          // status[1:0]
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_data  = '0;

    per_source_connection_limit_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the connection table and its limits
    logic               tbl_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  tbl_addr  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
    logic [IDLE_W-1:0]  tbl_idle  [TABLE_ENTRIES];
    logic [CFG_W-1:0]   lim_connect;
    logic [CFG_W-1:0]   lim_idle;

    req_t              queued_requests[$];
    res_t              awaited_verdicts[$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                errors  = 0;
    int                cycles  = 0;
    int                gap_pct = 7;
    bit                req_taken = 1'b0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run one request against the shadow table, giving the verdict it should produce
    function automatic res_t apply_table_op(req_t rq);
        res_t        r;
        int          slot;
        int          free_slot;
        int          freed;
        logic [16:0] sum;
        r         = '0;
        slot      = -1;
        free_slot = -1;
        freed     = 0;
        if (rq.cmd == CMD_OPEN || rq.cmd == CMD_CLOSE)
        begin
            // lowest matching entry wins, else the lowest free one
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (slot < 0)
                begin
                    if (tbl_valid[k])
                    begin
                        if (tbl_addr[k] == rq.addr)
                            slot = k;
                    end
                    else if (free_slot < 0)
                        free_slot = k;
                end
            end
            if (slot < 0 && free_slot >= 0)
            begin
                slot            = free_slot;
                tbl_valid[slot] = 1'b1;
                tbl_addr[slot]  = rq.addr;
                tbl_count[slot] = '0;
                tbl_idle[slot]  = '0;
            end
            if (slot < 0)
                r.status = STAT_FULL;
            else if (rq.cmd == CMD_OPEN)
            begin
                // limit checked before the add, so the count may overshoot
                if (tbl_count[slot] >= lim_connect)
                    r.status = STAT_REFUSED;
                else
                begin
                    sum = {1'b0, tbl_count[slot]} + rq.amount;
                    tbl_count[slot] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                end
                r.count_now = tbl_count[slot];
            end
            else
            begin
                tbl_idle[slot] = '0;
                if (tbl_count[slot] >= rq.amount)
                    tbl_count[slot] = tbl_count[slot] - rq.amount;
                r.count_now = tbl_count[slot];
            end
        end
        else if (rq.cmd == CMD_TICK)
        begin
            // age every entry, release the empty ones idle too long
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (tbl_valid[k])
                begin
                    if (tbl_idle[k] != IDLE_MAX)
                        tbl_idle[k] = tbl_idle[k] + 1'b1;
                    if (tbl_count[k] == '0 && tbl_idle[k] > lim_idle)
                    begin
                        tbl_valid[k] = 1'b0;
                        freed++;
                    end
                end
            end
            r.freed = (freed > 127) ? FREED_MAX : FREED_W'(freed);
        end
        return r;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        req_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    nxt = queued_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= {nxt.amount, nxt.addr};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // result checker and request capture
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d count %0d freed %0d",
                             $time, m_tuser, m_tdata[15:0], m_tdata[22:16]);
                    errors++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.count_now)
                    begin
                        $display("%0t: count_now mismatch, expected %0d, actual %0d",
                                 $time, want.count_now, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[22:16] !== want.freed)
                    begin
                        $display("%0t: freed_entries mismatch, expected %0d, actual %0d",
                                 $time, want.freed, m_tdata[22:16]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_verdicts.push_back(apply_table_op(
                    req_t'{cmd: s_tuser, addr: s_tdata[31:0], amount: s_tdata[39:32]}));
            req_taken <= s_tvalid && s_tready;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                             logic [AMOUNT_W-1:0] amount);
        queued_requests.push_back(req_t'{cmd: cmd, addr: addr, amount: amount});
    endtask

    // hold off until every request is answered and the engine has settled
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (queued_requests.size() != 0 || s_tvalid || awaited_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_CONNECT_LIMIT)
            lim_connect = val;
        else
            lim_idle = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly pooled addresses so entries get reused and the table fills
    task automatic queue_random(int n);
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        logic [AMOUNT_W-1:0] amount;
        repeat (n)
        begin
            pick = $urandom_range(99);
            cmd  = (pick < 45) ? CMD_OPEN : (pick < 80) ? CMD_CLOSE :
                   (pick < 97) ? CMD_TICK : CMD_UNUSED;
            addr = ($urandom_range(19) == 0) ? $urandom() : addr_pool[$urandom_range(POOL_SIZE-1)];
            pick = $urandom_range(9);
            if (pick < 5)
                amount = AMOUNT_W'($urandom_range(3));
            else if (pick < 9)
                amount = AMOUNT_W'($urandom_range(255));
            else
                amount = $urandom_range(1) ? 8'hff : 8'h00;
            queue_req(cmd, addr, amount);
        end
    endtask

    task automatic fill_table();
        for (int k = 0; k < POOL_SIZE; k++)
            queue_req(CMD_OPEN, addr_pool[k], AMOUNT_W'($urandom_range(1, 255)));
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] set_connect;
        logic [CFG_W-1:0] set_idle;
        lim_connect = CONNECT_LIMIT_RST;
        lim_idle    = IDLE_LIMIT_RST;
        for (int k = 0; k < TABLE_ENTRIES; k++)
            tbl_valid[k] = 1'b0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hffff_ffff;
        for (int k = 2; k < POOL_SIZE; k++)
            addr_pool[k] = $urandom();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: corner requests
        queue_req(CMD_OPEN,   32'h0000_0000, 8'h00);   // allocate with nothing added
        queue_req(CMD_OPEN,   32'hffff_ffff, 8'hff);   // overshoot past the limit
        queue_req(CMD_OPEN,   32'hffff_ffff, 8'h01);   // refused at the limit
        queue_req(CMD_CLOSE,  32'hffff_ffff, 8'hff);   // back down to zero
        queue_req(CMD_CLOSE,  32'h0000_0000, 8'h01);   // close below zero leaves the count
        queue_req(CMD_CLOSE,  32'h5a5a_a5a5, 8'h00);   // close allocates on a miss
        queue_req(CMD_OPEN,   32'h5a5a_a5a5, 8'h5a);
        queue_req(CMD_UNUSED, 32'ha5a5_5a5a, 8'ha5);   // unused command does nothing
        queue_req(CMD_TICK,   32'hffff_ffff, 8'hff);   // tick ignores address and amount
        queue_req(CMD_OPEN,   32'h0000_0001, 8'h80);
        queue_req(CMD_CLOSE,  32'h0000_0001, 8'h7f);
        queue_req(CMD_OPEN,   32'h0000_0000, 8'd99);
        wait_idle();

        // tightest limits: empty entries released on the next tick
        write_reg(REG_IDLE_LIMIT, 16'd0);
        write_reg(REG_CONNECT_LIMIT, 16'd1);
        queue_req(CMD_TICK,  32'h0000_0000, 8'h00);
        queue_req(CMD_OPEN,  32'h8000_0000, 8'd5);
        queue_req(CMD_OPEN,  32'h8000_0000, 8'd1);
        queue_req(CMD_CLOSE, 32'h8000_0000, 8'd5);
        queue_req(CMD_TICK,  32'h0000_0000, 8'h00);
        queue_req(CMD_TICK,  32'h0000_0000, 8'h00);
        wait_idle();

        // zero limit refuses every open
        write_reg(REG_CONNECT_LIMIT, 16'd0);
        queue_req(CMD_OPEN,  32'h1234_5678, 8'd3);
        queue_req(CMD_CLOSE, 32'h1234_5678, 8'd0);
        queue_req(CMD_TICK,  32'h0000_0000, 8'h00);
        wait_idle();

        // widest limits, count driven into saturation with no idling
        write_reg(REG_CONNECT_LIMIT, 16'hffff);
        write_reg(REG_IDLE_LIMIT, 16'hffff);
        gap_pct = 0;
        queue_req(CMD_OPEN, 32'hc0a8_0001, 8'd1);
        repeat (258) queue_req(CMD_OPEN, 32'hc0a8_0001, 8'hff);
        queue_req(CMD_CLOSE, 32'hc0a8_0001, 8'hff);
        queue_req(CMD_TICK,  32'h0000_0000, 8'h00);
        wait_idle();
        gap_pct = 7;

        // random traffic over several limit settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    set_connect = 16'd1;
                    set_idle    = 16'd0;
                end
                1:
                begin
                    set_connect = 16'hffff;
                    set_idle    = 16'hffff;
                end
                2:
                begin
                    set_connect = CFG_W'($urandom_range(2, 400));
                    set_idle    = CFG_W'($urandom_range(0, 3));
                end
                3:
                begin
                    set_connect = CFG_W'($urandom_range(1, 65535));
                    set_idle    = CFG_W'($urandom_range(0, 2));
                end
                default:
                begin
                    set_connect = 16'd10;
                    set_idle    = 16'd1;
                end
            endcase
            write_reg(REG_CONNECT_LIMIT, set_connect);
            write_reg(REG_IDLE_LIMIT, set_idle);
            if (ph == 3)
                fill_table();
            queue_random(30);
            wait_idle();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
src/plct_pkg.sv
src/plct_ram.sv
src/plct_engine.sv
src/per_source_connection_limit_table.sv
sim/tb_per_source_connection_limit_table.sv
